FILE: rtl/core/crtc_raster_timing_defines.svh
// assertion macros for the crtc raster timing checker
// no dependencies; included by files that carry assertions
`ifndef CRTC_RASTER_TIMING_DEFINES_SVH
`define CRTC_RASTER_TIMING_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CRTC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CRTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/crtc_pkg.sv
// shared types and constants of the crtc raster timing block
// no dependencies; used by controller, datapath and top level
`default_nettype none

package crtc_pkg;

  localparam int DotW    = 11;
  localparam int LineW   = 13;
  localparam int AddrW   = 16;
  localparam int CfgW    = 14;
  localparam int CfgIdxW = 3;
  localparam int ScanW   = 5;
  localparam int CharHW  = ScanW + 1;

  // residue divider runs one step per scanline bit
  localparam int DivSteps = LineW;
  localparam int StepW    = $clog2(DivSteps);
  localparam logic [StepW-1:0] StepLast = StepW'(DivSteps - 1);

  localparam logic [7:0]  ResetHorizTotal    = 8'd113;
  localparam logic [7:0]  ResetHorizDisplay  = 8'd80;
  localparam logic [6:0]  ResetVertTotal     = 7'd31;
  localparam logic [4:0]  ResetVertAdjust    = 5'd6;
  localparam logic [6:0]  ResetVertDisplay   = 7'd25;
  localparam logic [6:0]  ResetVsyncRow      = 7'd28;
  localparam logic [4:0]  ResetMaxScanLine   = 5'd7;
  localparam logic [13:0] ResetStartAddress  = 14'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HORIZ_TOTAL     = 3'd0,
    REG_HORIZ_DISPLAYED = 3'd1,
    REG_VERT_TOTAL      = 3'd2,
    REG_VERT_ADJUST     = 3'd3,
    REG_VERT_DISPLAYED  = 3'd4,
    REG_VSYNC_ROW       = 3'd5,
    REG_MAX_SCAN_LINE   = 3'd6,
    REG_START_ADDRESS   = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    ST_CALC,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_step;
  } dp_cmd_t;

  typedef struct packed {
    logic             display_enable;
    logic             vblank;
    logic             line_end;
    logic             line_visible;
    logic [DotW-1:0]  dot_position;
    logic [LineW-1:0] scan_line;
    logic [AddrW-1:0] row_address;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/crtc_ctrl.sv
// controller of the crtc raster timing block: sequencing and handshakes
// depends on crtc_pkg
`default_nettype none

module crtc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              s_tvalid,
  input  logic              m_tready,
  output logic              s_tready,
  output logic              m_tvalid,
  output crtc_pkg::dp_cmd_t cmd
);
  import crtc_pkg::*;

  ctrl_state_t      state;
  ctrl_state_t      state_next;
  logic [StepW-1:0] step_cnt;
  logic             out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CALC: begin
        if (!cfg_we && step_cnt == StepLast) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cfg_we) begin
          state_next = ST_CALC;
        end
      end
      default: state_next = ST_CALC;
    endcase
  end

  always_comb begin
    s_tready     = (state == ST_RUN) && (!out_valid || m_tready);
    cmd.accept   = s_tready && s_tvalid;
    cmd.div_load = cfg_we;
    cmd.div_step = (state == ST_CALC) && !cfg_we;
  end

  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CALC;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        step_cnt <= '0;
      end else if (state == ST_CALC) begin
        step_cnt <= step_cnt + StepW'(1);
      end
      if (cmd.accept) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/crtc_dpath.sv
// datapath of the crtc raster timing block: registers, counters, residue
// divider and result register; depends on crtc_pkg
`default_nettype none

module crtc_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [crtc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [crtc_pkg::CfgW-1:0]     cfg_data,
  input  crtc_pkg::dp_cmd_t             cmd,
  input  logic                          tick,
  output crtc_pkg::result_t             result
);
  import crtc_pkg::*;

  // configuration registers
  logic [7:0]  horiz_total;
  logic [7:0]  horiz_displayed;
  logic [6:0]  vert_total;
  logic [4:0]  vert_adjust;
  logic [6:0]  vert_displayed;
  logic [6:0]  vsync_row;
  logic [4:0]  max_scan_line;
  logic [13:0] start_address;

  // derived limits, settled while the controller runs the divider
  logic [DotW:0]    line_len;
  logic [LineW-1:0] total_lines;
  logic [LineW-1:0] v_vis;
  logic [LineW-1:0] vb_start;
  logic [DotW-1:0]  h_vis;
  logic [CharHW-1:0] char_h;

  // raster state
  logic [DotW-1:0]  dot_count;
  logic [LineW-1:0] line_count;
  logic [AddrW-1:0] row_addr;
  logic             vblank_flag;
  logic [ScanW-1:0] residue;      // line_count modulo char_h
  logic [LineW-1:0] div_bits;

  logic [DotW-1:0]  dot_next;
  logic [LineW-1:0] line_next;
  logic [AddrW-1:0] row_next;
  logic             vblank_next;
  logic [ScanW-1:0] residue_next;
  logic             ended;
  logic             visible;

  logic [DotW:0]     dot_inc;
  logic [LineW:0]    line_inc;
  logic [CharHW-1:0] residue_inc;
  logic [CharHW-1:0] div_trial;
  logic [ScanW-1:0]  div_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      horiz_total     <= ResetHorizTotal;
      horiz_displayed <= ResetHorizDisplay;
      vert_total      <= ResetVertTotal;
      vert_adjust     <= ResetVertAdjust;
      vert_displayed  <= ResetVertDisplay;
      vsync_row       <= ResetVsyncRow;
      max_scan_line   <= ResetMaxScanLine;
      start_address   <= ResetStartAddress;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HORIZ_TOTAL:     horiz_total     <= cfg_data[7:0];
        REG_HORIZ_DISPLAYED: horiz_displayed <= cfg_data[7:0];
        REG_VERT_TOTAL:      vert_total      <= cfg_data[6:0];
        REG_VERT_ADJUST:     vert_adjust     <= cfg_data[4:0];
        REG_VERT_DISPLAYED:  vert_displayed  <= cfg_data[6:0];
        REG_VSYNC_ROW:       vsync_row       <= cfg_data[6:0];
        REG_MAX_SCAN_LINE:   max_scan_line   <= cfg_data[4:0];
        REG_START_ADDRESS:   start_address   <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  assign char_h = {1'b0, max_scan_line} + CharHW'(1);
  assign h_vis  = {horiz_displayed, 3'b000};

  always_ff @(posedge clk) begin
    line_len    <= {({1'b0, horiz_total} + 9'd1), 3'b000};
    total_lines <= LineW'(({1'b0, vert_total} + 8'd1) * char_h) + LineW'(vert_adjust);
    v_vis       <= LineW'(vert_displayed * char_h);
    vb_start    <= LineW'(vsync_row * char_h);
  end

  assign dot_inc     = {1'b0, dot_count} + (DotW+1)'(1);
  assign line_inc    = {1'b0, line_count} + (LineW+1)'(1);
  assign residue_inc = {1'b0, residue} + CharHW'(1);

  always_comb begin
    dot_next     = dot_count;
    line_next    = line_count;
    row_next     = row_addr;
    vblank_next  = vblank_flag;
    residue_next = residue;
    ended        = 1'b0;
    visible      = 1'b0;
    if (cmd.accept && tick) begin
      if (dot_inc >= line_len) begin
        ended        = 1'b1;
        visible      = line_count < v_vis;
        dot_next     = '0;
        residue_next = residue_inc[ScanW-1:0];
        // character row boundary
        if (residue_inc == char_h) begin
          residue_next = '0;
          row_next     = row_addr + AddrW'({horiz_displayed, 1'b0});
        end
        if (line_inc >= {1'b0, total_lines}) begin
          line_next    = '0;
          row_next     = AddrW'({start_address, 1'b0});
          vblank_next  = 1'b0;
          residue_next = '0;
        end else begin
          if (line_inc >= {1'b0, vb_start}) begin
            vblank_next = 1'b1;
          end
          line_next = line_inc[LineW-1:0];
        end
      end else begin
        dot_next = dot_inc[DotW-1:0];
      end
    end
  end

  // restoring remainder step, one scanline bit per cycle
  assign div_trial = {residue, div_bits[LineW-1]};
  assign div_rem   = (div_trial >= char_h) ? ScanW'(div_trial - char_h)
                                           : div_trial[ScanW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count   <= '0;
      line_count  <= '0;
      row_addr    <= '0;
      vblank_flag <= 1'b0;
      residue     <= '0;
      div_bits    <= '0;
    end else begin
      dot_count   <= dot_next;
      line_count  <= line_next;
      row_addr    <= row_next;
      vblank_flag <= vblank_next;
      if (cmd.div_load) begin
        residue  <= '0;
        div_bits <= line_count;
      end else if (cmd.div_step) begin
        residue  <= div_rem;
        div_bits <= {div_bits[LineW-2:0], 1'b0};
      end else begin
        residue <= residue_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      result.display_enable <= (dot_next < h_vis) && (line_next < v_vis);
      result.vblank         <= vblank_next;
      result.line_end       <= ended;
      result.line_visible   <= visible;
      result.dot_position   <= dot_next;
      result.scan_line      <= line_next;
      result.row_address    <= row_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/crtc_raster_timing.sv
// channel   dir  beat content
// s_*       in   tdata[0] tick
// m_*       out  tdata: display_enable, vblank, line_visible, dot, line, address; tlast
// cfg_*     in   register write, index 0..7
//
// one beat per clock while s_tready is high; each result sits in the output register in the cycle after its beat
// a new beat is taken only while the output register is empty or its result leaves
// reset and every register write hold s_tready low while a
// one-bit-per-cycle divider rebuilds the scanline-in-row count
// a stalled master side holds the input side once the output register is full
`default_nettype none

module crtc_raster_timing (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,    // tick
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // display_enable, vblank, line_visible, dot_position, scan_line, row_address
  output logic [47:0]                   m_tdata,
  output logic                          m_tlast,    // line_end
  input  logic                          cfg_we,
  input  logic [crtc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [crtc_pkg::CfgW-1:0]     cfg_data
);
  import crtc_pkg::*;

  dp_cmd_t cmd;
  result_t result;

  crtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  crtc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .tick      (s_tdata[0]),
    .result    (result)
  );

  assign m_tdata = {5'b00000, result.row_address, result.scan_line, result.dot_position,
                    result.line_visible, result.vblank, result.display_enable};
  assign m_tlast = result.line_end;

endmodule

`default_nettype wire

FILE: rtl/core/crtc_checker.sv
// port-level checks of the crtc raster timing block, bound to the top level
// depends on crtc_pkg and crtc_raster_timing_defines.svh
`default_nettype none
`include "crtc_raster_timing_defines.svh"

module crtc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [7:0]                    s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [47:0]                   m_tdata,
  input logic                          m_tlast,
  input logic                          cfg_we,
  input logic [crtc_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [crtc_pkg::CfgW-1:0]     cfg_data
);
  import crtc_pkg::*;

  logic unused_cfg;
  assign unused_cfg = ^{cfg_index, cfg_data, s_tdata[7:1]};

  `CRTC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && !unused_cfg == !unused_cfg, "stalled result beat changed")
  `CRTC_ASSERT_SAME(a_line_end_dot, clk, rst, m_tvalid && m_tlast, m_tdata[13:3] == 11'd0, "line end beat with nonzero dot position")
  `CRTC_ASSERT_SAME(a_visible_end, clk, rst, m_tvalid && m_tdata[2], m_tlast, "visible line mark without line end")
  `CRTC_ASSERT_NEXT(a_hold_no_end, clk, rst, s_tvalid && s_tready && !s_tdata[0], !m_tlast, "held beat closed a line")
  `CRTC_ASSERT_NEXT(a_cfg_stall, clk, rst, cfg_we, !s_tready, "input taken right after a register write")

endmodule

bind crtc_raster_timing crtc_checker u_checker (.*);

`default_nettype wire
